/* rtl/hpq_pkg.sv */
`default_nettype none

package hpq_pkg;

    // Width of the entry count field on the result stream.
    localparam int COUNT_OUT_W = 13;

    // Operation codes of an input beat; code 3 leaves the heap alone but still gets a result.
    typedef enum logic [1:0] {
        OP_PEEK    = 2'd0,
        OP_EXTRACT = 2'd1,
        OP_INSERT  = 2'd2
    } t_op;

    // Status codes of a result beat.
    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2
    } t_status;

    // One heap entry; the id sits in the low half, as on the input stream.
    typedef struct packed {
        logic signed [31:0] prio;
        logic signed [31:0] id;
    } t_entry;

    // One result, laid out exactly as the result tdata from bit 0 up.
    typedef struct packed {
        logic [COUNT_OUT_W-1:0] count;
        logic signed [31:0]     prio;
        logic signed [31:0]     id;
        t_status                status;
    } t_result;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PEEK,
        ST_EX_LAST,
        ST_EX_LOAD,
        ST_SU_CMP,
        ST_SD_RD_R,
        ST_SD_CMP,
        ST_WR_CUR
    } t_state;

endpackage

`default_nettype wire

/* rtl/hpq_mem.sv */
`default_nettype none

module hpq_mem
    import hpq_pkg::*;
#(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire t_entry        i_wdata,
    input  wire logic          i_re,
    input  wire logic [AW-1:0] i_raddr,
    output t_entry             o_rdata
);

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port; the read data is registered.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* rtl/hpq_ctrl.sv */
`default_nettype none

module hpq_ctrl
    import hpq_pkg::*;
#(
    parameter int CAPACITY = 4096
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [1:0]                    i_op,
    input  wire t_entry                        i_entry,
    output logic                               o_idle,
    output logic                               o_res_valid,
    output t_result                            o_res,
    output logic                               o_mem_re,
    output logic [$clog2(CAPACITY)-1:0]        o_mem_raddr,
    input  wire t_entry                        i_mem_rdata,
    output logic                               o_mem_we,
    output logic [$clog2(CAPACITY)-1:0]        o_mem_waddr,
    output t_entry                             o_mem_wdata
);

    localparam int CW  = $clog2(CAPACITY + 1);
    localparam int AW  = $clog2(CAPACITY);
    localparam int CXW = (CW > COUNT_OUT_W) ? CW : COUNT_OUT_W;

    // Memory address of a 1-based heap index.
    function automatic logic [AW-1:0] f_addr(input logic [CW:0] k);
        logic [CW:0] km1;
        km1 = k - 1'b1;
        return km1[AW-1:0];
    endfunction

    // Low bits of the count as reported on the result stream.
    function automatic logic [COUNT_OUT_W-1:0] f_cnt(input logic [CW-1:0] c);
        logic [CXW-1:0] e;
        e = CXW'(c);
        return e[COUNT_OUT_W-1:0];
    endfunction

    t_state        r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_idx,   n_idx;
    t_entry        r_cur,   n_cur;
    t_entry        r_left,  n_left;
    logic          r_rvalid, n_rvalid;

    // Shared index arithmetic.
    logic [CW:0]   cnt_x, idx_x, left_x, right_x, child2_x;
    logic [CW-1:0] ins_idx, par_idx, child_idx;
    logic          l_win, r_win, sd_move, su_move;
    logic          ins_full, ins_root, par_above;
    logic signed [31:0] best_prio;

    assign cnt_x     = {1'b0, r_count};
    assign idx_x     = {1'b0, r_idx};
    assign left_x    = {r_idx, 1'b0};
    assign right_x   = {r_idx, 1'b1};
    assign ins_idx   = r_count + 1'b1;
    assign ins_full  = (r_count >= CW'(CAPACITY));
    assign ins_root  = (r_count == '0);
    assign par_idx   = r_idx >> 1;
    assign par_above = (par_idx > CW'(1));

    // Sift-down choice: strict compares, the left child wins ties.
    assign l_win     = (r_cur.prio < r_left.prio);
    assign best_prio = l_win ? r_left.prio : r_cur.prio;
    assign r_win     = r_rvalid && (best_prio < i_mem_rdata.prio);
    assign sd_move   = l_win || r_win;
    assign child_idx = r_win ? right_x[CW-1:0] : left_x[CW-1:0];
    assign child2_x  = {child_idx, 1'b0};

    // Sift-up: the parent just read moves down if it is strictly smaller.
    assign su_move   = (i_mem_rdata.prio < r_cur.prio);

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    if (i_op == OP_PEEK && r_count != '0) begin
                        n_state = ST_PEEK;
                    end else if (i_op == OP_EXTRACT && r_count != '0) begin
                        n_state = ST_EX_LAST;
                    end else if (i_op == OP_INSERT && !ins_full && !ins_root) begin
                        n_state = ST_SU_CMP;
                    end
                end
            end
            ST_PEEK:    n_state = ST_IDLE;
            ST_EX_LAST: n_state = ST_EX_LOAD;
            ST_EX_LOAD: begin
                if (r_count == '0) begin
                    n_state = ST_IDLE;
                end else if (r_count > CW'(1)) begin
                    n_state = ST_SD_RD_R;
                end else begin
                    n_state = ST_WR_CUR;
                end
            end
            ST_SU_CMP: begin
                if (!su_move) begin
                    n_state = ST_IDLE;
                end else if (!par_above) begin
                    n_state = ST_WR_CUR;
                end
            end
            ST_SD_RD_R: n_state = ST_SD_CMP;
            ST_SD_CMP: begin
                if (!sd_move) begin
                    n_state = ST_IDLE;
                end else if (child2_x <= cnt_x) begin
                    n_state = ST_SD_RD_R;
                end else begin
                    n_state = ST_WR_CUR;
                end
            end
            ST_WR_CUR:  n_state = ST_IDLE;
            default:    n_state = ST_IDLE;
        endcase
    end

    // Memory accesses, results and datapath registers.
    always_comb begin
        n_count      = r_count;
        n_idx        = r_idx;
        n_cur        = r_cur;
        n_left       = r_left;
        n_rvalid     = r_rvalid;
        o_res_valid  = 1'b0;
        o_res        = '{count: f_cnt(r_count), prio: '0, id: '0, status: STAT_OK};
        o_mem_re     = 1'b0;
        o_mem_raddr  = '0;
        o_mem_we     = 1'b0;
        o_mem_waddr  = f_addr(idx_x);
        o_mem_wdata  = r_cur;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    unique case (i_op)
                        OP_PEEK, OP_EXTRACT: begin
                            if (r_count == '0) begin
                                o_res_valid  = 1'b1;
                                o_res.status = STAT_EMPTY;
                            end else begin
                                o_mem_re    = 1'b1;
                                o_mem_raddr = '0;
                            end
                        end
                        OP_INSERT: begin
                            o_res_valid = 1'b1;
                            if (ins_full) begin
                                o_res.status = STAT_FULL;
                            end else begin
                                o_res.count = f_cnt(ins_idx);
                                n_count     = ins_idx;
                                n_idx       = ins_idx;
                                n_cur       = i_entry;
                                if (ins_root) begin
                                    o_mem_we    = 1'b1;
                                    o_mem_waddr = '0;
                                    o_mem_wdata = i_entry;
                                end else begin
                                    o_mem_re    = 1'b1;
                                    o_mem_raddr = f_addr({1'b0, ins_idx >> 1});
                                end
                            end
                        end
                        default: begin
                            o_res_valid = 1'b1;
                        end
                    endcase
                end
            end
            ST_PEEK: begin
                o_res_valid = 1'b1;
                o_res.id    = i_mem_rdata.id;
                o_res.prio  = i_mem_rdata.prio;
            end
            ST_EX_LAST: begin
                // Top is out; fetch the last entry, which moves to the root.
                o_res_valid = 1'b1;
                o_res.id    = i_mem_rdata.id;
                o_res.prio  = i_mem_rdata.prio;
                o_res.count = f_cnt(r_count - 1'b1);
                o_mem_re    = 1'b1;
                o_mem_raddr = f_addr(cnt_x);
                n_count     = r_count - 1'b1;
            end
            ST_EX_LOAD: begin
                n_cur = i_mem_rdata;
                n_idx = CW'(1);
                if (r_count > CW'(1)) begin
                    o_mem_re    = 1'b1;
                    o_mem_raddr = AW'(1);
                end
            end
            ST_SU_CMP: begin
                o_mem_we = 1'b1;
                if (su_move) begin
                    // Parent moves into the hole; continue one level up.
                    o_mem_wdata = i_mem_rdata;
                    n_idx       = par_idx;
                    if (par_above) begin
                        o_mem_re    = 1'b1;
                        o_mem_raddr = f_addr({1'b0, par_idx >> 1});
                    end
                end
            end
            ST_SD_RD_R: begin
                // Left child arrives; fetch the right one if it exists.
                n_left   = i_mem_rdata;
                n_rvalid = (right_x <= cnt_x);
                if (right_x <= cnt_x) begin
                    o_mem_re    = 1'b1;
                    o_mem_raddr = f_addr(right_x);
                end
            end
            ST_SD_CMP: begin
                o_mem_we = 1'b1;
                if (sd_move) begin
                    // Winning child moves up; continue below it.
                    o_mem_wdata = r_win ? i_mem_rdata : r_left;
                    n_idx       = child_idx;
                    if (child2_x <= cnt_x) begin
                        o_mem_re    = 1'b1;
                        o_mem_raddr = f_addr(child2_x);
                    end
                end
            end
            ST_WR_CUR: begin
                o_mem_we = 1'b1;
            end
            default: begin
                o_mem_we = 1'b0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_cur    <= n_cur;
        r_left   <= n_left;
        r_rvalid <= n_rvalid;
    end

    assign o_idle = (r_state == ST_IDLE);

endmodule

`default_nettype wire

/* rtl/binary_max_heap_priority_queue_core.sv */
`default_nettype none

// Priority queue of (id, priority) entries held as a binary max-heap.
// Input beats on the s-side carry an operation: peek, extract or insert.
// Every accepted beat yields exactly one result beat on the m-side with a
// status, the top entry for peek and extract, and the count afterwards.
// The heap sits in one single-port-read, single-port-write memory.
// Peek reads the root and puts it out as its result. Insert makes its result
// when the beat is taken, then sifts up with one memory read per level climbed.
// Extract makes its result from the root read, fetches the last entry and
// loads it as the new root, then sifts down with a left and a right child
// read per level, plus a last write when the entry ends on a leaf.
// The next beat is taken once the sift has finished.
// A finished result waits in a holding register, so a stalled receiver does
// not stop the next operation; input waits while that register is occupied.
// Reset empties the queue at once; memory contents need no clearing.
module binary_max_heap_priority_queue_core
    import hpq_pkg::*;
#(
    parameter int CAPACITY = 4096
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [71:0] i_s_tdata,  // op[1:0], entry_id[33:2], entry_priority[65:34]
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [79:0]      o_m_tdata   // status[1:0], top_id[33:2], top_priority[65:34],
                                         // entry_count[78:66]
);

    localparam int AW = $clog2(CAPACITY);

    logic          start, idle, res_valid, res_move;
    t_result       res;
    logic          mem_re, mem_we;
    logic [AW-1:0] mem_raddr, mem_waddr;
    t_entry        mem_rdata, mem_wdata;

    logic          r_res_pend, r_out_valid;
    t_result       r_res, r_out;

    assign o_s_tready = idle && !r_res_pend;
    assign start      = i_s_tvalid && o_s_tready;
    assign res_move   = r_res_pend && (!r_out_valid || i_m_tready);

    hpq_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_op        (i_s_tdata[1:0]),
        .i_entry     (t_entry'(i_s_tdata[65:2])),
        .o_idle      (idle),
        .o_res_valid (res_valid),
        .o_res       (res),
        .o_mem_re    (mem_re),
        .o_mem_raddr (mem_raddr),
        .i_mem_rdata (mem_rdata),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata)
    );

    hpq_mem #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // Holding register and output register valid flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_pend  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (res_move) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            if (res_valid) begin
                r_res_pend <= 1'b1;
            end else if (res_move) begin
                r_res_pend <= 1'b0;
            end
        end
    end

    // Result payloads.
    always_ff @(posedge i_clk) begin
        if (res_valid) begin
            r_res <= res;
        end
        if (res_move) begin
            r_out <= r_res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {1'b0, r_out};

endmodule

`default_nettype wire

/* tb/sv/hpq_checker.sv */
`timescale 1ns / 1ps

// Watches both streams of the heap queue, keeps its own copy of the heap,
// and checks every result beat against the oldest predicted result.
module hpq_checker
    import hpq_pkg::*;
#(
    parameter int CAPACITY = 4096
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    input  wire logic        i_s_tready,
    input  wire logic [71:0] i_s_tdata,   // op, entry_id, entry_priority
    input  wire logic        i_m_tvalid,
    input  wire logic        i_m_tready,
    input  wire logic [79:0] i_m_tdata,   // status, top_id, top_priority, entry_count
    output int               o_mismatches,
    output int               o_awaited
);

    // Shadow heap, 1-indexed, and the number of entries it holds.
    t_entry      heap_mem [1:CAPACITY];
    int unsigned heap_fill;

    // Results predicted but not yet seen on the output stream.
    t_result awaited_results [$];

    // Applies one operation to the shadow heap and returns the result it gives.
    function automatic t_result apply_heap_op(input logic [1:0] op, input t_entry ent);
        t_result     res;
        t_entry      tmp;
        int unsigned pos;
        int unsigned big;
        int unsigned kid;
        bit          settled;
        res = '0;
        res.status = STAT_OK;
        case (op)
            OP_PEEK, OP_EXTRACT: begin
                if (heap_fill == 0) begin
                    res.status = STAT_EMPTY;
                end else begin
                    res.id = heap_mem[1].id;
                    res.prio = heap_mem[1].prio;
                    if (op == OP_EXTRACT) begin
                        // The last entry moves to the root and sinks.
                        heap_mem[1] = heap_mem[heap_fill];
                        heap_fill--;
                        pos = 1;
                        settled = 1'b0;
                        while (!settled) begin
                            big = pos;
                            kid = 2 * pos;
                            if (kid <= heap_fill &&
                                $signed(heap_mem[big].prio) < $signed(heap_mem[kid].prio)) begin
                                big = kid;
                            end
                            // The right child must be strictly larger to win a tie.
                            if (kid + 1 <= heap_fill &&
                                $signed(heap_mem[big].prio) < $signed(heap_mem[kid + 1].prio)) begin
                                big = kid + 1;
                            end
                            if (big == pos) begin
                                settled = 1'b1;
                            end else begin
                                tmp = heap_mem[pos];
                                heap_mem[pos] = heap_mem[big];
                                heap_mem[big] = tmp;
                                pos = big;
                            end
                        end
                    end
                end
            end
            OP_INSERT: begin
                if (heap_fill >= CAPACITY) begin
                    res.status = STAT_FULL;
                end else begin
                    // Append at the end and let the new entry climb.
                    heap_fill++;
                    heap_mem[heap_fill] = ent;
                    pos = heap_fill;
                    while (pos > 1 &&
                           $signed(heap_mem[pos / 2].prio) < $signed(heap_mem[pos].prio)) begin
                        tmp = heap_mem[pos];
                        heap_mem[pos] = heap_mem[pos / 2];
                        heap_mem[pos / 2] = tmp;
                        pos = pos / 2;
                    end
                end
            end
            default: begin
                // The unused code leaves the heap alone.
            end
        endcase
        res.count = COUNT_OUT_W'(heap_fill);
        return res;
    endfunction

    // Reports one field that differs from its prediction.
    task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            o_mismatches++;
        end
    endtask

    // Predict on every accepted input beat, compare on every accepted result beat.
    always @(posedge i_clk) begin
        t_result want;
        t_result got;
        if (!i_rst_n) begin
            heap_fill = 0;
            awaited_results.delete();
            o_awaited = 0;
            o_mismatches = 0;
        end else begin
            if (i_s_tvalid && i_s_tready) begin
                awaited_results.push_back(apply_heap_op(i_s_tdata[1:0],
                                                        t_entry'(i_s_tdata[65:2])));
            end
            if (i_m_tvalid && i_m_tready) begin
                got = t_result'(i_m_tdata[78:0]);
                if (awaited_results.size() == 0) begin
                    $display("%0t: unexpected result beat, expected none, actual %h",
                             $time, got);
                    o_mismatches++;
                end else begin
                    want = awaited_results.pop_front();
                    check_field("status", 32'(want.status), 32'(got.status));
                    check_field("top_id", want.id, got.id);
                    check_field("top_priority", want.prio, got.prio);
                    check_field("entry_count", 32'(want.count), 32'(got.count));
                end
            end
            o_awaited = awaited_results.size();
        end
    end

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps

module tb
    import hpq_pkg::*;
();

    localparam int HEAP_DEPTH = 4096;

    // The operation code that leaves the heap alone.
    localparam logic [1:0] OP_NONE = 2'd3;

    localparam logic [31:0] VAL_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] VAL_MIN = 32'h8000_0000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [79:0] m_tdata;

    int          mismatches;
    int          awaited;

    // Idle rates in percent for the sending and receiving side.
    int          s_idle_pct = 29;
    int          m_idle_pct = 86;

    // Number of entries the queue holds once every sent beat is done.
    int unsigned held_entries = 0;

    // Clock with a 10 ns period.
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    binary_max_heap_priority_queue_core #(
        .CAPACITY(HEAP_DEPTH)
    ) DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata)
    );

    hpq_checker #(
        .CAPACITY(HEAP_DEPTH)
    ) u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .o_mismatches (mismatches),
        .o_awaited    (awaited)
    );

    // Receiver stalls at random.
    always @(negedge clk) begin
        m_tready <= ($urandom_range(0, 99) >= m_idle_pct);
    end

    // Priority mix: full range, ties near zero, extremes, and a narrow band.
    function automatic logic [31:0] rand_prio();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return 32'($urandom_range(0, 4)) - 32'd2;
            2: begin
                case ($urandom_range(0, 3))
                    0: return VAL_MAX;
                    1: return VAL_MIN;
                    2: return 32'd0;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
            default: return 32'($urandom_range(0, 8192)) - 32'd4096;
        endcase
    endfunction

    // Sends one beat; called and returning at a falling edge.
    task automatic push_beat(input logic [1:0] op, input logic [31:0] id,
                             input logic [31:0] prio);
        while ($urandom_range(0, 99) < s_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {6'd0, prio, id, op};
        do @(posedge clk); while (!s_tready);
        if (op == OP_INSERT && held_entries < HEAP_DEPTH) begin
            held_entries++;
        end else if (op == OP_EXTRACT && held_entries > 0) begin
            held_entries--;
        end
        @(negedge clk);
    endtask

    // Random operations around a fill level that wanders, now and then to empty.
    task automatic run_random(input int beats);
        int unsigned roll;
        int unsigned insert_pct;
        int unsigned target;
        logic [1:0]  op;
        target = 0;
        for (int k = 0; k < beats; k++) begin
            if (k % 60 == 0) begin
                target = $urandom_range(0, 80);
            end
            insert_pct = (held_entries < target) ? 60 : 30;
            roll = $urandom_range(0, 99);
            if (roll < insert_pct) begin
                op = OP_INSERT;
            end else if (roll < 90) begin
                op = OP_EXTRACT;
            end else if (roll < 97) begin
                op = OP_PEEK;
            end else begin
                op = OP_NONE;
            end
            push_beat(op, $urandom, rand_prio());
        end
    endtask

    // Run limit.
    initial begin
        #20_000_000;
        $display("tb: FAIL");
        $finish;
    end

    // Stimulus and verdict.
    initial begin
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Operations on an empty queue.
        push_beat(OP_PEEK, 32'd7, 32'd7);
        push_beat(OP_EXTRACT, 32'd7, 32'd7);
        push_beat(OP_NONE, VAL_MAX, VAL_MIN);

        // Extreme ids and priorities, with ties on zero and on the maximum.
        push_beat(OP_INSERT, VAL_MAX, VAL_MAX);
        push_beat(OP_INSERT, VAL_MIN, VAL_MIN);
        push_beat(OP_INSERT, 32'd0, 32'd0);
        push_beat(OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_beat(OP_INSERT, 32'd5, 32'd0);
        push_beat(OP_INSERT, 32'd6, VAL_MAX);
        push_beat(OP_PEEK, 32'd0, 32'd0);
        push_beat(OP_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        repeat (6) push_beat(OP_EXTRACT, 32'd0, 32'd0);

        // Equal children after the last entry reaches the root: left one rises.
        push_beat(OP_INSERT, 32'd10, 32'h0000_0900);
        push_beat(OP_INSERT, 32'd11, 32'h0000_0300);
        push_beat(OP_INSERT, 32'd12, 32'h0000_0300);
        push_beat(OP_INSERT, 32'd13, 32'h0000_0100);
        repeat (4) push_beat(OP_EXTRACT, 32'd0, 32'd0);

        run_random(400);

        s_idle_pct = 86;
        m_idle_pct = 29;
        run_random(400);

        s_idle_pct = 0;
        m_idle_pct = 0;
        run_random(400);

        // Drain to empty, then extract once more from the empty queue.
        while (held_entries > 0) begin
            push_beat(OP_EXTRACT, 32'd0, 32'd0);
        end
        push_beat(OP_EXTRACT, 32'd0, 32'd0);
        s_tvalid <= 1'b0;

        // Drain the results, then allow for a late stray beat.
        while (awaited != 0) @(negedge clk);
        repeat (64) @(negedge clk);

        if (mismatches == 0 && awaited == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule
